[src/sha256_pkg.sv]
`timescale 1ns / 1ps
package sha256_pkg;
   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int Rounds = 64;
   localparam int DigestWords = 8;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        word_last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_byte;    // write byte into the block buffer
      logic [7:0] load_value;
      logic [5:0] load_pos;
      logic       round_start;  // copy chaining hash into working variables
      logic       round_step;   // one compression round
      logic [5:0] round_index;
      logic       round_finish; // add working variables into the chaining hash
      logic       hash_init;    // reload initial hash values
      logic       digest_shift; // rotate chaining hash by one word
   } cmd_type;

   localparam word_type RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
   };

   localparam word_type InitialHash [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
   };

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthPos = 6'd56;
endpackage

[src/sha256_if.sv]
`timescale 1ns / 1ps
interface sha256_req_if;
   logic valid;
   logic ready;
   sha256_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha256_rsp_if;
   logic valid;
   logic ready;
   sha256_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/sha256_message_hasher.sv]
`timescale 1ns / 1ps
// SHA-256 hasher over a byte stream. Each request word carries one message byte, an
// end-of-message mark, or both; a byte arriving with the mark is included in the message.
// A byte that does not fill the 64-byte block is stored and the hasher stays ready. The
// 64th byte starts the compression: 64 rounds on one shared round unit at one round per
// cycle, then a fold into the chaining hash; no new byte is taken until it is done. At the
// end mark the controller writes the padding one byte per cycle up to the block end,
// compresses, and, when fewer than nine bytes were free, pads and compresses one more
// block. The digest then leaves as eight response words, most significant first, with
// word_last on the eighth; afterwards the initial hash values are reloaded for the next
// message. The bit length wraps modulo 2^64.
module sha256_message_hasher (
   input logic          clock,
   input logic          reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   sha256_pkg::cmd_type  cmd;
   sha256_pkg::word_type digest_head;

   sha256_controller u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .digest_head(digest_head), .cmd(cmd)
   );

   sha256_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .digest_head(digest_head)
   );

`ifndef ASSERT_OFF
   // Never take a request while a digest word is offered.
   assert property (@(posedge clock) disable iff (reset) !(req.ready && rsp.valid))
      else $error("request taken during digest output");
   // A compression and a digest rotation never coincide.
   assert property (@(posedge clock) disable iff (reset)
      !((cmd.round_step || cmd.round_finish) && cmd.digest_shift))
      else $error("round and digest shift together");
   // The last word completes the digest and returns to accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.payload.word_last |=> req.ready)
      else $error("not idle after last digest word");
`endif
endmodule

[src/sha256_datapath.sv]
`timescale 1ns / 1ps
module sha256_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sha256_pkg::cmd_type  cmd,
   output sha256_pkg::word_type digest_head
);
   // The block buffer holds sixteen big-endian words; byte 4r is the top byte of word r.
   sha256_pkg::word_type block_ff [16];
   sha256_pkg::word_type sched_ff [16];
   sha256_pkg::word_type work_ff [8];
   sha256_pkg::word_type work_in [8];
   sha256_pkg::word_type hash_ff [8];
   sha256_pkg::word_type w_cur, w_new, t1, t2, a, e, w2, w15, s0, s1;
   logic [3:0] slot;

   function automatic sha256_pkg::word_type rotr(sha256_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   assign slot = cmd.round_index[3:0];
   assign w2 = sched_ff[4'(slot - 4'd2)];
   assign w15 = sched_ff[4'(slot - 4'd15)];
   assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign w_new = s1 + sched_ff[4'(slot - 4'd7)] + s0 + sched_ff[slot];

   always_comb begin
      if (cmd.round_index[5:4] == 2'd0) begin
         w_cur = block_ff[slot];
      end else begin
         w_cur = w_new;
      end
      a = work_ff[0];
      e = work_ff[4];
      t1 = work_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & work_ff[5]) ^ (~e & work_ff[6]))
         + sha256_pkg::RoundK[cmd.round_index] + w_cur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         block_ff[cmd.load_pos[5:2]][{~cmd.load_pos[1:0], 3'd0} +: 8] <= cmd.load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_start) begin
         work_ff <= hash_ff;
      end else if (cmd.round_step) begin
         work_ff <= work_in;
         sched_ff[slot] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.hash_init) begin
         hash_ff <= sha256_pkg::InitialHash;
      end else if (cmd.round_finish) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
      end else if (cmd.digest_shift) begin
         for (int i = 0; i < 7; i++) begin
            hash_ff[i] <= hash_ff[i + 1];
         end
         hash_ff[7] <= hash_ff[0];
      end
   end

   assign digest_head = hash_ff[0];
endmodule

[src/sha256_controller.sv]
`timescale 1ns / 1ps
module sha256_controller (
   input  logic                 clock,
   input  logic                 reset,
   sha256_req_if.sink           req,
   sha256_rsp_if.source         rsp,
   input  sha256_pkg::word_type digest_head,
   output sha256_pkg::cmd_type  cmd
);
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StRound  = 3'd1;
   localparam logic [2:0] StFinish = 3'd2;
   localparam logic [2:0] StPad    = 3'd3;
   localparam logic [2:0] StEmit   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] emit_ff, emit_in;
   logic end_ff, end_in;       // finishing is pending after current compression
   logic extra_ff, extra_in;   // the next pad block is a length-only block
   logic padded_ff, padded_in; // current compression is the final block
   logic [5:0] pad_ff, pad_in;
   logic [7:0] pad_byte;

   // Padding byte at position pad_ff: 0x80 at the fill point, length bytes at the tail
   // of the final block, zero otherwise.
   always_comb begin
      if (pad_ff == fill_ff && !extra_ff) begin
         pad_byte = sha256_pkg::PadByte;
      end else if (pad_ff >= sha256_pkg::LengthPos && (extra_ff || fill_ff < 6'd56)) begin
         pad_byte = 8'(len_ff >> (6'd56 - {pad_ff[2:0], 3'd0}));
      end else begin
         pad_byte = 8'd0;
      end
   end

   assign req.ready = (state_ff == StIdle);
   assign rsp.valid = (state_ff == StEmit);
   assign rsp.payload.digest_word = digest_head;
   assign rsp.payload.word_last = (emit_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      round_in = round_ff;
      emit_in = emit_ff;
      end_in = end_ff;
      extra_in = extra_ff;
      padded_in = padded_ff;
      pad_in = pad_ff;
      cmd = '0;
      cmd.round_index = round_ff;
      cmd.load_value = pad_byte;
      cmd.load_pos = pad_ff;
      unique case (state_ff)
         StIdle: begin
            if (req.valid) begin
               if (req.payload.byte_present) begin
                  cmd.load_byte = 1'b1;
                  cmd.load_value = req.payload.byte_value;
                  cmd.load_pos = fill_ff;
                  fill_in = fill_ff + 6'd1;
                  len_in = len_ff + 64'd8;
               end
               end_in = req.payload.message_end;
               padded_in = 1'b0;
               extra_in = 1'b0;
               if (req.payload.byte_present && fill_ff == 6'd63) begin
                  cmd.round_start = 1'b1;
                  round_in = '0;
                  state_in = StRound;
               end else if (req.payload.message_end) begin
                  pad_in = fill_in;
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            // Writes one padding byte a cycle from the fill point (byte 0 for a second pad block) to the block end.
            cmd.load_byte = 1'b1;
            pad_in = pad_ff + 6'd1;
            if (pad_ff == 6'd63) begin
               cmd.round_start = 1'b1;
               round_in = '0;
               padded_in = extra_ff || fill_ff < 6'd56;
               state_in = StRound;
            end
         end
         StRound: begin
            cmd.round_step = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            cmd.round_finish = 1'b1;
            if (padded_ff) begin
               emit_in = '0;
               state_in = StEmit;
            end else if (end_ff && fill_ff != 6'd0 && !extra_ff) begin
               // 0x80 did not leave room for the length: one more block.
               extra_in = 1'b1;
               pad_in = '0;
               state_in = StPad;
            end else if (end_ff) begin
               pad_in = '0;
               fill_in = '0;
               state_in = StPad;
            end else begin
               state_in = StIdle;
            end
         end
         StEmit: begin
            if (rsp.ready) begin
               cmd.digest_shift = 1'b1;
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  cmd.digest_shift = 1'b0;
                  cmd.hash_init = 1'b1;
                  fill_in = '0;
                  len_in = '0;
                  end_in = 1'b0;
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fill_ff <= '0;
         len_ff <= '0;
         end_ff <= 1'b0;
         extra_ff <= 1'b0;
         padded_ff <= 1'b0;
         round_ff <= '0;
         emit_ff <= '0;
         pad_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         end_ff <= end_in;
         extra_ff <= extra_in;
         padded_ff <= padded_in;
         round_ff <= round_in;
         emit_ff <= emit_in;
         pad_ff <= pad_in;
      end
   end
endmodule

[sim/sha256_message_hasher_test.sv]
`timescale 1ns / 1ps
module sha256_message_hasher_test;
   logic clock;
   logic reset;

   sha256_req_if req_if ();
   sha256_rsp_if rsp_if ();

   sha256_message_hasher uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Predictor state: chaining hash, the bytes of the current block and the
   // running bit count of the message.
   sha256_pkg::word_type hash_state [8];
   logic [7:0]  block_bytes [64];
   int          byte_fill;
   logic [63:0] message_bits;

   // Digest words that the block still owes us, oldest first.
   sha256_pkg::rsp_type digest_queue [$];

   int error_count;
   int stall_percent_send;
   int stall_percent_recv;
   bit hold_receiver;
   int idle_cycles;

   function automatic sha256_pkg::word_type ror(sha256_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One SHA-256 compression of block_bytes into hash_state.
   function automatic void compress_block();
      sha256_pkg::word_type w [64];
      sha256_pkg::word_type v [8];
      sha256_pkg::word_type t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      for (int r = 16; r < 64; r++)
         w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
              + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   function automatic void start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitialHash[i];
      byte_fill = 0;
      message_bits = '0;
   endfunction

   // Advances the predictor by one accepted word and queues any digest words.
   function automatic void predict_digest(sha256_pkg::req_type item);
      int pos;
      sha256_pkg::rsp_type word;
      if (item.byte_present) begin
         block_bytes[byte_fill] = item.byte_value;
         message_bits += 64'd8;
         byte_fill = (byte_fill + 1) % 64;
         if (byte_fill == 0) compress_block();
      end
      if (!item.message_end) return;
      pos = byte_fill;
      block_bytes[pos] = sha256_pkg::PadByte;
      pos++;
      if (pos > 56) begin
         while (pos < 64) block_bytes[pos++] = 8'h00;
         compress_block();
         pos = 0;
      end
      while (pos < 56) block_bytes[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = message_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = hash_state[i];
         word.word_last = (i == 7);
         digest_queue.push_back(word);
      end
      start_message();
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Sends one word, waiting for the handshake; the sender may idle first.
   // Ready is looked at in the middle of the cycle, where it holds the value
   // that the next rising edge sees.
   task automatic send_word(sha256_pkg::req_type item);
      bit taken;
      while ($urandom_range(99) < stall_percent_send) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
      predict_digest(item);
   endtask

   task automatic send_idle();
      req_if.valid <= 1'b0;
   endtask

   // Random message of the given length, ending either with a byte+end word
   // or with an end-only word; occasionally an ignored empty word is mixed in.
   task automatic send_message(int length);
      sha256_pkg::req_type item;
      bit end_with_byte;
      end_with_byte = (length > 0) && $urandom_range(1);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(19) == 0) begin
            item = '{byte_value: 8'($urandom), byte_present: 1'b0, message_end: 1'b0};
            send_word(item);
         end
         item.byte_value = 8'($urandom);
         item.byte_present = 1'b1;
         item.message_end = end_with_byte && (i == length - 1);
         send_word(item);
      end
      if (!end_with_byte) begin
         item = '{byte_value: 8'($urandom), byte_present: 1'b0, message_end: 1'b1};
         send_word(item);
      end
   endtask

   task automatic wait_drained();
      send_idle();
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // Directed words. A nonzero digest column gives the first digest word,
   // which can be read off at a glance for well-known messages.
   typedef struct {
      sha256_pkg::req_type  item;
      sha256_pkg::word_type first_word;
   } directed_row;

   directed_row directed [] = '{
      // Empty message: the well-known digest of nothing.
      '{'{8'h00, 1'b0, 1'b1}, 32'he3b0c442},
      // "abc", the last byte arriving together with the end mark.
      '{'{8'h61, 1'b1, 1'b0}, 32'h0},
      '{'{8'h62, 1'b1, 1'b0}, 32'h0},
      '{'{8'h63, 1'b1, 1'b1}, 32'hba7816bf},
      // A word with neither byte nor end does nothing.
      '{'{8'hff, 1'b0, 1'b0}, 32'h0},
      // Extreme byte values, then an end-only word.
      '{'{8'hff, 1'b1, 1'b0}, 32'h0},
      '{'{8'h00, 1'b1, 1'b0}, 32'h0},
      '{'{8'haa, 1'b1, 1'b0}, 32'h0},
      '{'{8'h55, 1'b1, 1'b0}, 32'h0},
      '{'{8'h00, 1'b0, 1'b1}, 32'h0},
      // An empty message after another message shows the hash was reloaded, then a one-byte message.
      '{'{8'h5a, 1'b0, 1'b1}, 32'he3b0c442},
      '{'{8'hff, 1'b1, 1'b1}, 32'h0}
   };

   // Response side: random stall, forced hold-off, and the checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_receiver && ($urandom_range(99) >= stall_percent_recv);
      end
   end

   always @(posedge clock) begin
      sha256_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_if.payload.digest_word, 32'h0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_if.payload.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_if.payload.digest_word, want.digest_word);
            if (rsp_if.payload.word_last !== want.word_last)
               report_mismatch("word_last", 32'(rsp_if.payload.word_last),
                               32'(want.word_last));
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no handshake at all.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || hold_receiver) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("sha256_message_hasher_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      stall_percent_send = 0;
      stall_percent_recv = 0;
      hold_receiver = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      start_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; rows with a typed value get an extra check of the
      // predictor's first digest word before it is compared with the block.
      foreach (directed[i]) begin
         send_word(directed[i].item);
         if (directed[i].first_word != 32'h0) begin
            if (digest_queue.size() != 8 || digest_queue[0].digest_word != directed[i].first_word)
               report_mismatch("known digest", digest_queue[0].digest_word,
                               directed[i].first_word);
         end
      end
      // Lengths around the padding boundaries: 55 fits one block, 56 spills
      // into an extra block, 63 and 64 sit at the block edge.
      send_message(55);
      send_message(56);
      send_message(63);
      send_message(64);
      wait_drained();

      // Long hold-off on the receiver while the sender keeps offering.
      hold_receiver = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_receiver = 1'b0;
         end
         begin
            send_message(3);
            send_message(0);
            send_message(9);
         end
      join
      wait_drained();

      // Random part in three phases of sender and receiver idling, the last without any.
      for (int phase = 0; phase < 3; phase++) begin
         stall_percent_send = (phase == 0) ? 30 : (phase == 1) ? 52 : 0;
         stall_percent_recv = (phase == 0) ? 52 : (phase == 1) ? 30 : 0;
         for (int n = 0; n < 44; ) begin
            int length;
            length = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            send_message(length);
            n += length + 1;
            // The sender sometimes pauses until all digests are in.
            if ($urandom_range(7) == 0) wait_drained();
         end
      end
      stall_percent_send = 0;
      stall_percent_recv = 0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("sha256_message_hasher_test: done, clean");
      end else begin
         $display("sha256_message_hasher_test: done, errors");
      end
      $finish;
   end
endmodule

[sim.f]
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_datapath.sv
src/sha256_controller.sv
src/sha256_message_hasher.sv
sim/sha256_message_hasher_test.sv
